@@ rtl/psa_pkg.sv @@
// ----------------------------------------------------------------------------
// psa_pkg
// Shared constants, codes and types of the playback source arbiter.
// ----------------------------------------------------------------------------
package psa_pkg;

	// number of source slots, slot 0 means no source
	localparam int unsigned SOURCE_COUNT = 4;
	localparam int unsigned SLOT_W       = $clog2(SOURCE_COUNT);

	// field widths
	localparam int unsigned SOURCE_W = 4;
	localparam int unsigned ACTION_W = 3;
	localparam int unsigned EVENT_W  = 3;

	typedef logic [SOURCE_W-1:0] source_t;
	typedef logic [ACTION_W-1:0] action_t;
	typedef logic [EVENT_W-1:0]  event_t;

	// per-source playback state
	typedef enum logic [1:0] {
		ST_IDLE      = 2'd0,
		ST_CONNECTED = 2'd1,
		ST_PLAYING   = 2'd2,
		ST_PAUSED    = 2'd3
	} slot_state_t;

	// input actions
	localparam action_t ACT_CONNECTED    = 3'd0;
	localparam action_t ACT_PLAYING      = 3'd1;
	localparam action_t ACT_PAUSED       = 3'd2;
	localparam action_t ACT_DISCONNECTED = 3'd3;
	localparam action_t ACT_METADATA     = 3'd4;

	// notification codes
	localparam event_t EV_CONNECTED    = 3'd0;
	localparam event_t EV_PLAYING      = 3'd1;
	localparam event_t EV_PAUSED       = 3'd2;
	localparam event_t EV_DISCONNECTED = 3'd3;
	localparam event_t EV_METADATA     = 3'd4;

	// one notification word
	typedef struct packed {
		event_t  notify_event;
		source_t event_source;
		logic    last;
		source_t active_source;
		logic    any_connected;
		logic    any_playing;
	} result_t;

	// words produced by one command, handed to the output buffer
	typedef struct packed {
		logic       load;
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} batch_t;

endpackage

@@ rtl/psa_in_if.sv @@
// ----------------------------------------------------------------------------
// psa_in_if
// Command channel: source number and action, valid/ready handshake.
// ----------------------------------------------------------------------------
interface psa_in_if;
	import psa_pkg::*;

	logic    valid;
	logic    ready;
	source_t source;
	action_t action;

	modport src (output valid, output source, output action, input ready);
	modport snk (input valid, input source, input action, output ready);
endinterface

@@ rtl/psa_out_if.sv @@
// ----------------------------------------------------------------------------
// psa_out_if
// Notification channel: event word with aggregate status, valid/ready.
// ----------------------------------------------------------------------------
interface psa_out_if;
	import psa_pkg::*;

	logic    valid;
	logic    ready;
	event_t  notify_event;
	source_t event_source;
	logic    last;
	source_t active_source;
	logic    any_connected;
	logic    any_playing;

	modport src (
		output valid, output notify_event, output event_source, output last,
		output active_source, output any_connected, output any_playing,
		input ready
	);
	modport snk (
		input valid, input notify_event, input event_source, input last,
		input active_source, input any_connected, input any_playing,
		output ready
	);
endinterface

@@ rtl/psa_engine.sv @@
// ----------------------------------------------------------------------------
// psa_engine
// Command register, per-source state, display holder and the single-pass
// update that turns one command into zero, one or two notification words.
// ----------------------------------------------------------------------------
module psa_engine (
	input  logic           clk,
	input  logic           arst_n,
	psa_in_if.snk          cmd,
	input  logic           load_ok,
	output psa_pkg::batch_t batch
);
	import psa_pkg::*;

	logic        valid_s1;
	source_t     source_s1;
	action_t     action_s1;
	slot_state_t state_q [SOURCE_COUNT];
	source_t     holder_q;

	logic        go;
	logic        src_ok;
	logic        known;
	logic        apply;
	logic        forward;
	logic [SLOT_W-1:0] slot;
	slot_state_t cur;
	slot_state_t nxt;
	slot_state_t new_state [SOURCE_COUNT];
	logic        wc, wp, nc, np;
	source_t     holder_mid;
	source_t     holder_new;
	source_t     play_idx, any_idx;
	logic        c_up, p_up, p_dn, d_dn;
	event_t      ev [2];
	logic [1:0]  n;
	logic [1:0]  count;
	source_t     act_out;
	logic        conn_out, play_out;

	// command register, refilled whenever the held command moves on
	assign go        = valid_s1 && load_ok;
	assign cmd.ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			source_s1 <= cmd.source;
			action_s1 <= cmd.action;
		end
	end

	// decode of the held command
	always_comb begin
		slot   = source_s1[SLOT_W-1:0];
		src_ok = (source_s1 != '0) &&
			({1'b0, source_s1} < (SOURCE_W+1)'(SOURCE_COUNT));
		cur    = state_q[slot];
		known  = 1'b1;
		nxt    = ST_IDLE;
		unique case (action_s1)
			ACT_CONNECTED:    nxt = ST_CONNECTED;
			ACT_PLAYING:      nxt = ST_PLAYING;
			ACT_PAUSED:       nxt = ST_PAUSED;
			ACT_DISCONNECTED: nxt = ST_IDLE;
			default:          known = 1'b0;
		endcase
		// connect from a busy source and repeated states are dropped
		apply   = go && src_ok && known && cur != nxt &&
			!(nxt == ST_CONNECTED && cur != ST_IDLE);
		forward = go && src_ok && action_s1 == ACT_METADATA &&
			(holder_q == source_s1 || holder_q == '0);
	end

	// aggregate flags before and after the update
	always_comb begin
		wc = 1'b0;
		wp = 1'b0;
		nc = 1'b0;
		np = 1'b0;
		for (int i = 0; i < SOURCE_COUNT; i++) begin
			new_state[i] = (apply && slot == SLOT_W'(i)) ? nxt : state_q[i];
		end
		for (int i = 1; i < SOURCE_COUNT; i++) begin
			wc = wc || state_q[i] != ST_IDLE;
			wp = wp || state_q[i] == ST_PLAYING;
			nc = nc || new_state[i] != ST_IDLE;
			np = np || new_state[i] == ST_PLAYING;
		end
	end

	// display handover: lowest playing source, else lowest busy one
	always_comb begin
		play_idx = '0;
		any_idx  = '0;
		for (int i = SOURCE_COUNT - 1; i >= 1; i--) begin
			if (new_state[i] == ST_PLAYING) begin
				play_idx = SOURCE_W'(i);
			end
			if (new_state[i] != ST_IDLE) begin
				any_idx = SOURCE_W'(i);
			end
		end
		priority if (nxt == ST_PLAYING) begin
			holder_mid = source_s1;
		end else if (holder_q == source_s1 && nxt == ST_IDLE) begin
			holder_mid = '0;
		end else if (holder_q == '0 && nxt != ST_IDLE) begin
			holder_mid = source_s1;
		end else begin
			holder_mid = holder_q;
		end
		holder_new = (holder_mid == '0 && nc) ? (np ? play_idx : any_idx) : holder_mid;
	end

	// aggregate transitions, in order, at most two
	always_comb begin
		c_up  = !wc && nc;
		p_up  = !wp && np;
		p_dn  = wp && !np && nc;
		d_dn  = wc && !nc;
		n     = '0;
		ev[0] = EV_CONNECTED;
		ev[1] = EV_CONNECTED;
		if (c_up) begin
			ev[n[0]] = EV_CONNECTED;
			n        = n + 2'd1;
		end
		if (p_up) begin
			ev[n[0]] = EV_PLAYING;
			n        = n + 2'd1;
		end else if (p_dn) begin
			ev[n[0]] = EV_PAUSED;
			n        = n + 2'd1;
		end
		if (d_dn && n < 2'd2) begin
			ev[n[0]] = EV_DISCONNECTED;
			n        = n + 2'd1;
		end
	end

	// words handed to the output buffer
	always_comb begin
		count    = forward ? 2'd1 : (apply ? n : 2'd0);
		act_out  = apply ? holder_new : holder_q;
		conn_out = apply ? nc : wc;
		play_out = apply ? np : wp;

		batch.load                 = go;
		batch.count                = count;
		batch.first.notify_event   = forward ? EV_METADATA : ev[0];
		batch.first.event_source   = source_s1;
		batch.first.last           = count == 2'd1;
		batch.first.active_source  = act_out;
		batch.first.any_connected  = conn_out;
		batch.first.any_playing    = play_out;
		batch.second.notify_event  = ev[1];
		batch.second.event_source  = source_s1;
		batch.second.last          = 1'b1;
		batch.second.active_source = act_out;
		batch.second.any_connected = conn_out;
		batch.second.any_playing   = play_out;
	end

	// source states and display holder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SOURCE_COUNT; i++) begin
				state_q[i] <= ST_IDLE;
			end
			holder_q <= '0;
		end else if (apply) begin
			state_q[slot] <= nxt;
			holder_q      <= holder_new;
		end
	end

endmodule

@@ rtl/psa_out_buf.sv @@
// ----------------------------------------------------------------------------
// psa_out_buf
// Two-word result register: holds the words of one command and presents them
// one per cycle on the notification channel while the receiver is ready.
// ----------------------------------------------------------------------------
module psa_out_buf (
	input  logic            clk,
	input  logic            arst_n,
	input  psa_pkg::batch_t batch,
	output logic            load_ok,
	psa_out_if.src          evt
);
	import psa_pkg::*;

	result_t    slot_q [2];
	logic [1:0] count_q;
	logic       pop;

	assign pop     = evt.valid && evt.ready;
	assign load_ok = (count_q == 2'd0) || (count_q == 2'd1 && evt.ready);

	// word count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (batch.load) begin
			count_q <= batch.count;
		end else if (pop) begin
			count_q <= count_q - 2'd1;
		end
	end

	// word storage, second word moves to the head on a pop
	always_ff @(posedge clk) begin
		if (batch.load) begin
			slot_q[0] <= batch.first;
			slot_q[1] <= batch.second;
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
		end
	end

	assign evt.valid         = count_q != 2'd0;
	assign evt.notify_event  = slot_q[0].notify_event;
	assign evt.event_source  = slot_q[0].event_source;
	assign evt.last          = slot_q[0].last;
	assign evt.active_source = slot_q[0].active_source;
	assign evt.any_connected = slot_q[0].any_connected;
	assign evt.any_playing   = slot_q[0].any_playing;

endmodule

@@ rtl/playback_source_arbiter.sv @@
// ----------------------------------------------------------------------------
// playback_source_arbiter
// Tracks per-source playback state and the display holder, forwards metadata
// and reports aggregate connected/playing transitions.
// ----------------------------------------------------------------------------
// A command is taken into a register, evaluated combinationally against the
// per-source state and the display holder, and its notification words (none,
// one or two) are loaded into a two-word output register. The command channel
// accepts a new word every cycle as long as the output keeps up: a command
// giving one word runs at one per cycle, while one giving two words holds off
// the next command until its first word has been taken, as the single output
// port drains one word per cycle. Commands that are dropped produce no word.
// The first word of a command passes the command register and then the output
// register before it is presented, and the output register takes the words
// of a command only when it has room.
// ----------------------------------------------------------------------------
module playback_source_arbiter (
	input logic clk,
	input logic arst_n,
	psa_in_if.snk  cmd,
	psa_out_if.src evt
);
	import psa_pkg::*;

	batch_t batch;
	logic   load_ok;

	// command evaluation and state
	psa_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.load_ok (load_ok),
		.batch   (batch)
	);

	// result register
	psa_out_buf u_out_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.batch   (batch),
		.load_ok (load_ok),
		.evt     (evt)
	);

	// the engine only commits when the result register has room
	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		batch.load |-> load_ok)
		else $error("command evaluated while result register full");

	// a committed command with words shows them next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		batch.load && batch.count != 2'd0 |=> evt.valid)
		else $error("loaded words not presented");

	// a non-final word is followed by the rest of the same command
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid && evt.ready && !evt.last |=> evt.valid && $stable(evt.event_source))
		else $error("second word of a command lost");

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives command words into the playback source arbiter and checks each
// notification word against a predictor that tracks per-source state and the
// display holder. Runs directed cases, then random traffic under several
// idle and stall patterns, including a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import psa_pkg::*;

	// action codes the block must ignore
	localparam action_t ACT_UNUSED_5 = 3'd5;
	localparam action_t ACT_UNUSED_6 = 3'd6;
	localparam action_t ACT_UNUSED_7 = 3'd7;

	// cycles allowed for a dropped command still in flight
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_WORDS  = 500;

	// predictor of the notification words plus the queue of words still due
	class notify_board;
		slot_state_t slot_st[SOURCE_COUNT];
		source_t     holder;
		result_t     due_words[$];
		int          errors;

		function new();
			foreach (slot_st[i]) slot_st[i] = ST_IDLE;
			holder = '0;
			errors = 0;
		endfunction

		// aggregate flags over the valid slots
		function void agg_flags(output logic conn, output logic play);
			conn = 1'b0;
			play = 1'b0;
			for (int i = 1; i < SOURCE_COUNT; i++) begin
				if (slot_st[i] != ST_IDLE) conn = 1'b1;
				if (slot_st[i] == ST_PLAYING) play = 1'b1;
			end
		endfunction

		function void push_word(event_t ev, source_t s, logic lst, logic conn, logic play);
			result_t w;
			w.notify_event  = ev;
			w.event_source  = s;
			w.last          = lst;
			w.active_source = holder;
			w.any_connected = conn;
			w.any_playing   = play;
			due_words.push_back(w);
		endfunction

		// accepted command: update state and queue the words it causes
		function void note_command(source_t s, action_t a);
			slot_state_t nxt;
			logic        was_conn, was_play, now_conn, now_play;
			event_t      evs[2];
			int          n;
			n = 0;
			if (s == '0 || s >= SOURCE_COUNT) return;

			// metadata goes through only for the holder or when nobody holds
			if (a == ACT_METADATA) begin
				if (holder == s || holder == '0) begin
					agg_flags(now_conn, now_play);
					push_word(EV_METADATA, s, 1'b1, now_conn, now_play);
				end
				return;
			end

			case (a)
				ACT_CONNECTED:    nxt = ST_CONNECTED;
				ACT_PLAYING:      nxt = ST_PLAYING;
				ACT_PAUSED:       nxt = ST_PAUSED;
				ACT_DISCONNECTED: nxt = ST_IDLE;
				default:          return;
			endcase

			if (nxt == ST_CONNECTED && slot_st[s] != ST_IDLE) return;
			if (slot_st[s] == nxt) return;

			agg_flags(was_conn, was_play);
			slot_st[s] = nxt;

			// display holder update
			if (nxt == ST_PLAYING) begin
				holder = s;
			end else if (holder == s && nxt == ST_IDLE) begin
				holder = '0;
			end else if (holder == '0 && nxt != ST_IDLE) begin
				holder = s;
			end

			agg_flags(now_conn, now_play);

			// handover: lowest playing slot, else lowest non-idle one
			if (holder == '0 && now_conn) begin
				for (int i = 1; i < SOURCE_COUNT; i++) begin
					if (slot_st[i] == ST_PLAYING) begin
						holder = source_t'(i);
						break;
					end
					if (slot_st[i] != ST_IDLE && holder == '0) holder = source_t'(i);
				end
			end

			// aggregate transitions, at most two
			if (!was_conn && now_conn) begin
				evs[n] = EV_CONNECTED;
				n++;
			end
			if (!was_play && now_play) begin
				evs[n] = EV_PLAYING;
				n++;
			end else if (was_play && !now_play && now_conn) begin
				evs[n] = EV_PAUSED;
				n++;
			end
			if (was_conn && !now_conn && n < 2) begin
				evs[n] = EV_DISCONNECTED;
				n++;
			end
			for (int k = 0; k < n; k++)
				push_word(evs[k], s, k == n - 1, now_conn, now_play);
		endfunction

		function void report_field(string name, int unsigned want, int unsigned got);
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			errors++;
		endfunction

		// accepted notification word against the oldest one due
		function void check_word(result_t got);
			result_t want;
			if (due_words.size() == 0) begin
				$display("%0t: unexpected word, expected none, got event %0d source %0d",
					$time, got.notify_event, got.event_source);
				errors++;
				return;
			end
			want = due_words.pop_front();
			if (got.notify_event !== want.notify_event)
				report_field("notify_event", want.notify_event, got.notify_event);
			if (got.event_source !== want.event_source)
				report_field("event_source", want.event_source, got.event_source);
			if (got.last !== want.last)
				report_field("last", want.last, got.last);
			if (got.active_source !== want.active_source)
				report_field("active_source", want.active_source, got.active_source);
			if (got.any_connected !== want.any_connected)
				report_field("any_connected", want.any_connected, got.any_connected);
			if (got.any_playing !== want.any_playing)
				report_field("any_playing", want.any_playing, got.any_playing);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	psa_in_if  cmd_if();
	psa_out_if evt_if();

	playback_source_arbiter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.evt    (evt_if)
	);

	notify_board board = new();

	int idle_pct  = 0;
	int stall_pct = 0;
	int hold_left = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// output side: random stalls, or a long hold-off when asked
	initial begin
		evt_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				evt_if.ready <= 1'b0;
			end else begin
				evt_if.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// check every accepted notification word
	always @(posedge clk) begin : watch_evt
		result_t got;
		if (arst_n && evt_if.valid && evt_if.ready) begin
			got.notify_event  = evt_if.notify_event;
			got.event_source  = evt_if.event_source;
			got.last          = evt_if.last;
			got.active_source = evt_if.active_source;
			got.any_connected = evt_if.any_connected;
			got.any_playing   = evt_if.any_playing;
			board.check_word(got);
		end
	end

	// offer one command word, with a random gap first, and wait for acceptance
	task automatic send_cmd(input source_t s, input action_t a);
		while ($urandom_range(99) < idle_pct) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_if.valid  <= 1'b1;
		cmd_if.source <= s;
		cmd_if.action <= a;
		do @(posedge clk); while (!cmd_if.ready);
		board.note_command(s, a);
	endtask

	// stop offering and let every due word come out
	task automatic wait_drain();
		cmd_if.valid <= 1'b0;
		while (board.due_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mostly valid sources and actions, some noise on every bit
	task automatic random_cmds(input int count);
		action_t pick[5];
		source_t s;
		action_t a;
		int      sent;
		pick = '{ACT_CONNECTED, ACT_PLAYING, ACT_PAUSED, ACT_DISCONNECTED, ACT_METADATA};
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(9) == 0) begin
				s = source_t'($urandom_range(15));
				a = action_t'($urandom_range(7));
			end else begin
				s = source_t'($urandom_range(SOURCE_COUNT - 1, 1));
				a = pick[$urandom_range(4)];
			end
			send_cmd(s, a);
			if (s != '0 && s < SOURCE_COUNT && a <= ACT_METADATA) sent++;
		end
	endtask

	// directed cases from reset
	task automatic directed_cmds();
		send_cmd(4'd0,  ACT_CONNECTED);     // source none
		send_cmd(4'd4,  ACT_CONNECTED);     // source out of range
		send_cmd(4'd15, ACT_PLAYING);       // out of range, all bits set
		send_cmd(4'd1,  ACT_UNUSED_5);      // unknown action
		send_cmd(4'd2,  ACT_UNUSED_7);      // unknown action, all bits set
		send_cmd(4'd1,  ACT_METADATA);      // nobody holds, forwarded
		send_cmd(4'd1,  ACT_CONNECTED);     // first connect
		send_cmd(4'd1,  ACT_CONNECTED);     // connect when not idle
		send_cmd(4'd2,  ACT_METADATA);      // not the holder, dropped
		send_cmd(4'd2,  ACT_CONNECTED);     // no flag change
		send_cmd(4'd2,  ACT_PLAYING);       // playing rises, takes display
		send_cmd(4'd1,  ACT_METADATA);      // dropped
		send_cmd(4'd2,  ACT_METADATA);      // holder, forwarded
		send_cmd(4'd2,  ACT_PLAYING);       // repeated state
		send_cmd(4'd3,  ACT_PLAYING);       // idle straight to playing, flags unchanged
		send_cmd(4'd3,  ACT_PAUSED);        // another still playing
		send_cmd(4'd2,  ACT_PAUSED);        // playing falls
		send_cmd(4'd2,  ACT_DISCONNECTED);  // not the holder
		send_cmd(4'd3,  ACT_DISCONNECTED);  // holder leaves, handover to lowest
		send_cmd(4'd1,  ACT_PAUSED);        // connected to paused
		send_cmd(4'd1,  ACT_DISCONNECTED);  // last one out
		send_cmd(4'd3,  ACT_PLAYING);       // connected and playing together
		send_cmd(4'd3,  ACT_DISCONNECTED);  // disconnected without paused
		send_cmd(4'd1,  ACT_UNUSED_6);      // unknown action
		send_cmd(4'd8,  ACT_DISCONNECTED);  // high source bit only
	endtask

	// main sequence
	initial begin
		arst_n        = 1'b0;
		cmd_if.valid  = 1'b0;
		cmd_if.source = '0;
		cmd_if.action = ACT_CONNECTED;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_cmds();
		wait_drain();

		// output held off for a long stretch while commands keep coming
		hold_left = 250;
		random_cmds(40);
		wait_drain();

		// no idling
		idle_pct  = 0;
		stall_pct = 0;
		random_cmds(RANDOM_WORDS / 4);
		// sender mostly idle
		idle_pct  = 72;
		stall_pct = 0;
		random_cmds(RANDOM_WORDS / 4);
		// receiver mostly stalling
		idle_pct  = 0;
		stall_pct = 72;
		random_cmds(RANDOM_WORDS / 4);
		// both sides idle now and then
		idle_pct  = 27;
		stall_pct = 27;
		random_cmds(RANDOM_WORDS / 4);

		wait_drain();
		if (board.errors == 0 && board.due_words.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// hang guard
	initial begin
		#400_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
